// ===== rtl/sab_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the superpixel adjacency builder.
// No dependencies; every other file in rtl/ imports this package.
package sab_pkg;

	// Fixed field widths.
	localparam int LBL_W = 8;
	localparam int CFG_W = 10;
	localparam int CNT_W = 16;

	// Parameter defaults.
	localparam int DEF_LABEL_COUNT = 256;
	localparam int DEF_MAX_WIDTH   = 512;
	localparam int DEF_MAX_HEIGHT  = 512;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
	localparam logic [CFG_W-1:0]     FRAME_SIZE_RST   = 10'd512;

	// Saturation value of the pair counter.
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	// Result queue sizing.
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_FILL_W = $clog2(OUT_DEPTH + 1);

	// Lookup slots of one pixel, in result order.
	localparam int NSLOT     = 7;
	localparam int NPAIRSLOT = 6;
	localparam int SLOT_W    = 3;
	localparam logic [SLOT_W-1:0] SLOT_LEFT     = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_UPLEFT   = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_UP       = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_UPRIGHT  = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_FIRSTROW = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_COLWRAP  = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_DONE     = 3'd6;

	// One lookup request from the scan stage to the pair table.
	typedef struct packed {
		logic             valid;
		logic [LBL_W-1:0] lo;
		logic [LBL_W-1:0] hi;
		logic             done;
	} pair_req_t;

	// One result item.
	typedef struct packed {
		logic [LBL_W-1:0] pair_low;
		logic [LBL_W-1:0] pair_high;
		logic             frame_done;
		logic [CNT_W-1:0] pair_count;
	} result_t;

endpackage

// ===== rtl/sab_scan.sv =====
`timescale 1ns / 1ps
// Raster scan front end: position counters, previous-row and first-row
// line memories, neighbor compare and one-per-cycle dispatch while issue_ok allows. Uses sab_pkg.
module sab_scan #(
	parameter int LABEL_COUNT = sab_pkg::DEF_LABEL_COUNT,
	parameter int MAX_WIDTH   = sab_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = sab_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sab_pkg::CFG_W-1:0]  frame_width,
	input  logic [sab_pkg::CFG_W-1:0]  frame_height,
	input  logic                       pixel_valid,
	output logic                       pixel_ready,
	input  logic [sab_pkg::LBL_W-1:0]  pixel_label,
	input  logic                       issue_ok,
	output sab_pkg::pair_req_t         req
);
	import sab_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RH = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	// A label at or above LABEL_COUNT takes part in no pair.
	function automatic logic lbl_ok(input logic [LBL_W-1:0] l);
		return (LABEL_COUNT >= 256) || (32'(l) < LABEL_COUNT);
	endfunction

	logic [CW-1:0]    col_q;
	logic [RH-1:0]    row_q;
	logic [LBL_W-1:0] left_q;
	logic [LBL_W-1:0] rstart_q;
	logic [LBL_W-1:0] upleft_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [CW-1:0] c;
	logic [RH-1:0] r;
	logic [CW-1:0] c_nxt;
	logic [RH-1:0] r_nxt;
	logic [CW-1:0] ur_addr;
	logic          last_col;
	logic          last_row;
	logic          ur_ok;
	logic          acc;

	logic [LBL_W-1:0] prev_mem [MAX_WIDTH];
	logic [LBL_W-1:0] first_mem [MAX_WIDTH];

	// Stage 1 registers.
	logic             valid_s1;
	logic [NSLOT-1:0] pend_s1;
	logic [LBL_W-1:0] cur_s1;
	logic [LBL_W-1:0] up_s1;
	logic [LBL_W-1:0] ur_s1;
	logic [LBL_W-1:0] first_s1;
	logic             col0_s1;
	logic             row0_s1;
	logic             urok_s1;
	logic             lastcol_s1;
	logic             lastrow_s1;

	logic [LBL_W-1:0] rs;
	logic [LBL_W-1:0] first_fwd;
	logic [LBL_W-1:0] cand_lbl [NPAIRSLOT];
	logic [NSLOT-1:0] cond;
	logic [NSLOT-1:0] live;
	logic [NSLOT-1:0] pick_oh;
	logic [SLOT_W-1:0] sel;
	logic [LBL_W-1:0] other;
	logic             issue;
	logic             retire;

	// Effective frame size and clipped position of the incoming pixel.
	always_comb begin
		if (frame_width == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width);
		end
		if (frame_height == '0) begin
			h_eff = HW'(1);
		end else if (32'(frame_height) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(frame_height);
		end
		c = (WW'(col_q) >= w_eff) ? CW'(w_eff - WW'(1)) : col_q;
		r = (HW'(row_q) >= h_eff) ? RH'(h_eff - HW'(1)) : row_q;
		last_col = (WW'(c) + WW'(1)) >= w_eff;
		last_row = (HW'(r) + HW'(1)) >= h_eff;
		ur_ok    = ((WW+1)'(c) + (WW+1)'(2)) < (WW+1)'(w_eff);
		c_nxt    = last_col ? '0 : c + CW'(1);
		r_nxt    = last_row ? '0 : r + RH'(1);
		ur_addr  = c_nxt;
	end

	assign acc = pixel_valid && pixel_ready;

	// Position counters advance on each accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= c_nxt;
			if (last_col) begin
				row_q <= r_nxt;
			end else begin
				row_q <= r;
			end
		end
	end

	// Line memories: read before write at the acceptance edge.
	always_ff @(posedge clk) begin
		if (acc) begin
			prev_mem[c] <= pixel_label;
			if (r == '0) begin
				first_mem[c] <= pixel_label;
			end
			up_s1      <= prev_mem[c];
			ur_s1      <= prev_mem[ur_addr];
			first_s1   <= first_mem[c];
			cur_s1     <= pixel_label;
			col0_s1    <= (c == '0);
			row0_s1    <= (r == '0);
			urok_s1    <= ur_ok;
			lastcol_s1 <= last_col;
			lastrow_s1 <= last_row;
		end
	end

	// Candidate pairs of the pixel held in stage 1.
	always_comb begin
		rs        = col0_s1 ? cur_s1 : rstart_q;
		first_fwd = row0_s1 ? cur_s1 : first_s1;
		cand_lbl[SLOT_LEFT]     = left_q;
		cand_lbl[SLOT_UPLEFT]   = upleft_q;
		cand_lbl[SLOT_UP]       = up_s1;
		cand_lbl[SLOT_UPRIGHT]  = ur_s1;
		cand_lbl[SLOT_FIRSTROW] = first_fwd;
		cand_lbl[SLOT_COLWRAP]  = rs;
		cond[SLOT_LEFT]     = !col0_s1 && (left_q != cur_s1);
		cond[SLOT_UPLEFT]   = !row0_s1 && !col0_s1 && (upleft_q != cur_s1);
		cond[SLOT_UP]       = !row0_s1 && (up_s1 != cur_s1);
		cond[SLOT_UPRIGHT]  = !row0_s1 && urok_s1 && (ur_s1 != cur_s1);
		cond[SLOT_FIRSTROW] = lastrow_s1;
		cond[SLOT_COLWRAP]  = lastcol_s1;
		for (int i = 0; i < NPAIRSLOT; i++) begin
			cond[i] = cond[i] && lbl_ok(cand_lbl[i]) && lbl_ok(cur_s1);
		end
		cond[SLOT_DONE] = lastrow_s1 && lastcol_s1;
	end

	// Pick the lowest pending slot each cycle.
	always_comb begin
		live = valid_s1 ? (pend_s1 & cond) : '0;
		sel  = SLOT_DONE;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (live[i]) begin
				sel = SLOT_W'(i);
			end
		end
		pick_oh = NSLOT'(1) << sel;
		issue   = (|live) && issue_ok;
		retire  = valid_s1 && (!(|live) || (issue && ((live & ~pick_oh) == '0)));
		other   = (sel == SLOT_DONE) ? cur_s1 : cand_lbl[sel];
	end

	assign pixel_ready = !valid_s1 || retire;

	// Request toward the pair table.
	always_comb begin
		req.valid = issue;
		req.done  = (sel == SLOT_DONE);
		if (sel == SLOT_DONE) begin
			req.lo = '0;
			req.hi = '0;
		end else if (other < cur_s1) begin
			req.lo = other;
			req.hi = cur_s1;
		end else begin
			req.lo = cur_s1;
			req.hi = other;
		end
	end

	// Stage 1 control and the neighbor history registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_s1  <= '0;
			left_q   <= '0;
			rstart_q <= '0;
			upleft_q <= '0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
				pend_s1  <= '1;
			end else begin
				if (retire) begin
					valid_s1 <= 1'b0;
				end
				if (issue) begin
					pend_s1 <= pend_s1 & ~pick_oh;
				end
			end
			if (retire) begin
				left_q   <= cur_s1;
				rstart_q <= rs;
				if (!row0_s1) begin
					upleft_q <= up_s1;
				end
			end
		end
	end

endmodule

// ===== rtl/sab_pair_table.sv =====
`timescale 1ns / 1ps
// Pair table: one row of seen bits per smaller label, read-modify-write with
// forwarding, row valid bits for instant clearing, and the pair counter. Uses sab_pkg.
module sab_pair_table #(
	parameter int LABEL_COUNT = sab_pkg::DEF_LABEL_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sab_pkg::pair_req_t  req,
	output logic                busy,
	output logic                res_valid,
	output sab_pkg::result_t    res
);
	import sab_pkg::*;

	localparam int NROW = (LABEL_COUNT < 256) ? LABEL_COUNT : 256;
	localparam int RW   = $clog2(NROW);
	localparam logic [NROW-1:0] BIT_ONE = NROW'(1);

	logic [NROW-1:0] pair_mem [NROW];

	logic             valid_s1;
	logic [LBL_W-1:0] lo_s1;
	logic [LBL_W-1:0] hi_s1;
	logic             done_s1;
	logic [NROW-1:0]  rd_word_s1;

	logic [NROW-1:0]  row_vld_q;
	logic             fwd_v_q;
	logic [RW-1:0]    fwd_row_q;
	logic [NROW-1:0]  fwd_word_q;
	logic [CNT_W-1:0] cnt_q;

	logic [RW-1:0]   row;
	logic [RW-1:0]   col;
	logic [NROW-1:0] base;
	logic [NROW-1:0] new_word;
	logic            seen;
	logic            wr_en;

	assign row  = lo_s1[RW-1:0];
	assign col  = hi_s1[RW-1:0];
	assign busy = valid_s1;

	// Current row contents: invalid rows read as clear, last write forwarded.
	always_comb begin
		if (!row_vld_q[row]) begin
			base = '0;
		end else if (fwd_v_q && (fwd_row_q == row)) begin
			base = fwd_word_q;
		end else begin
			base = rd_word_s1;
		end
		seen     = base[col];
		new_word = base | (BIT_ONE << col);
		wr_en    = valid_s1 && !done_s1 && !seen;
	end

	// Result of the lookup in flight.
	always_comb begin
		res_valid = valid_s1 && (done_s1 || !seen);
		if (done_s1) begin
			res.pair_low   = '0;
			res.pair_high  = '0;
			res.frame_done = 1'b1;
			res.pair_count = cnt_q;
		end else begin
			res.pair_low   = lo_s1;
			res.pair_high  = hi_s1;
			res.frame_done = 1'b0;
			res.pair_count = '0;
		end
	end

	// Pair memory and lookup stage payload.
	always_ff @(posedge clk) begin
		if (req.valid && !req.done) begin
			rd_word_s1 <= pair_mem[req.lo[RW-1:0]];
		end
		if (wr_en) begin
			pair_mem[row] <= new_word;
		end
		if (req.valid) begin
			lo_s1   <= req.lo;
			hi_s1   <= req.hi;
			done_s1 <= req.done;
		end
		fwd_row_q  <= row;
		fwd_word_q <= new_word;
	end

	// Control: stage valid, forwarding flag, row valid bits and pair count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fwd_v_q   <= 1'b0;
			row_vld_q <= '0;
			cnt_q     <= '0;
		end else begin
			valid_s1 <= req.valid;
			fwd_v_q  <= wr_en;
			if (valid_s1 && done_s1) begin
				row_vld_q <= '0;
				cnt_q     <= '0;
			end else if (wr_en) begin
				row_vld_q[row] <= 1'b1;
				if (cnt_q != CNT_MAX) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/sab_out_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue between the pair table and the result channel.
// Uses sab_pkg for the result type and queue sizing.
module sab_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  sab_pkg::result_t              push_data,
	output logic [sab_pkg::OUT_FILL_W-1:0] fill,
	output logic                          result_valid,
	input  logic                          result_ready,
	output sab_pkg::result_t              head
);
	import sab_pkg::*;

	result_t              slots_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_FILL_W-1:0] fill_q;
	logic                 pop;

	assign result_valid = (fill_q != '0);
	assign pop          = result_valid && result_ready;
	assign head         = slots_q[rd_ptr_q];
	assign fill         = fill_q;

	// Storage; the issue credit guarantees room on every push.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + OUT_FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - OUT_FILL_W'(1);
			end
		end
	end

endmodule

// ===== rtl/superpixel_adjacency_builder.sv =====
`timescale 1ns / 1ps
// Path: a pixel is held in the scan stage 1 registers; its lookups pass the pair table stage to the queue.
// Throughput: a pixel's pair lookups plus frame-end result (0 to 7) issue one a cycle while the queue
// has room, through the single read-modify-write port of the pair memory; the next pixel enters as the last issues.
// Reset: counters, history and pair-row valid bits clear at once; no clearing pass.
// Line memories hold undefined data until written. Frame end clears the pair table.
module superpixel_adjacency_builder #(
	parameter int LABEL_COUNT = sab_pkg::DEF_LABEL_COUNT,
	parameter int MAX_WIDTH   = sab_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = sab_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [sab_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sab_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  logic [sab_pkg::LBL_W-1:0]     pixel_label,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [sab_pkg::LBL_W-1:0]     pair_low,
	output logic [sab_pkg::LBL_W-1:0]     pair_high,
	output logic                          frame_done,
	output logic [sab_pkg::CNT_W-1:0]     pair_count
);
	import sab_pkg::*;

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	pair_req_t             req;
	logic                  issue_ok;
	logic                  tbl_busy;
	logic                  res_valid;
	result_t               res;
	result_t               head;
	logic [OUT_FILL_W-1:0] fill;
	logic [OUT_FILL_W:0]   committed;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_SIZE_RST;
			frame_height_q <= FRAME_SIZE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A lookup may issue only if the queue can take its result.
	assign committed = {1'b0, fill} + (OUT_FILL_W + 1)'(tbl_busy);
	assign issue_ok  = committed < (OUT_FILL_W + 1)'(OUT_DEPTH);

	sab_scan #(
		.LABEL_COUNT (LABEL_COUNT),
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_label  (pixel_label),
		.issue_ok     (issue_ok),
		.req          (req)
	);

	sab_pair_table #(
		.LABEL_COUNT (LABEL_COUNT)
	) u_pair_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.busy      (tbl_busy),
		.res_valid (res_valid),
		.res       (res)
	);

	sab_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (res_valid),
		.push_data    (res),
		.fill         (fill),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.head         (head)
	);

	assign pair_low   = head.pair_low;
	assign pair_high  = head.pair_high;
	assign frame_done = head.frame_done;
	assign pair_count = head.pair_count;

endmodule

// ===== test/superpixel_adjacency_builder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for superpixel_adjacency_builder: label frames in, adjacency pairs out.
// Depends on sab_pkg and the block's RTL; a built-in predictor checks every result in order.
module superpixel_adjacency_builder_tb;
	import sab_pkg::*;

	localparam int unsigned RUN_LIMIT = 400000;
	localparam int unsigned QUIET_CYCLES = 12;
	localparam int unsigned MAXW = DEF_MAX_WIDTH;
	localparam int unsigned MAXH = DEF_MAX_HEIGHT;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	logic [LBL_W-1:0] pixel_label = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [LBL_W-1:0] pair_low;
	logic [LBL_W-1:0] pair_high;
	logic frame_done;
	logic [CNT_W-1:0] pair_count;

	// Idle rates of the pixel sender and the result receiver, in percent.
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;

	// Predictor state: sizes, scan position, line stores and the pair table.
	logic [CFG_W-1:0] size_w = FRAME_SIZE_RST;
	logic [CFG_W-1:0] size_h = FRAME_SIZE_RST;
	int unsigned scan_col = 0;
	int unsigned scan_row = 0;
	logic [LBL_W-1:0] line_above [0:MAXW-1];
	logic [LBL_W-1:0] top_line [0:MAXW-1];
	logic [LBL_W-1:0] row_head = '0;
	logic [LBL_W-1:0] left_lbl = '0;
	logic [LBL_W-1:0] diag_lbl = '0;
	bit pair_seen [0:DEF_LABEL_COUNT*DEF_LABEL_COUNT-1];
	int seen_list [$];
	logic [CNT_W-1:0] pairs_found = '0;
	result_t pending_reports [$];
	result_t head_report;

	superpixel_adjacency_builder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel_label(pixel_label),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.pair_low(pair_low),
		.pair_high(pair_high),
		.frame_done(frame_done),
		.pair_count(pair_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("superpixel_adjacency_builder_tb: done, errors");
			$finish;
		end
	end

	// The receiver stalls at random according to its idle rate.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Compare each accepted result with the oldest predicted one.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: pair_low %0d pair_high %0d frame_done %0d pair_count %0d",
					pair_low, pair_high, frame_done, pair_count);
				err_count++;
			end else begin
				head_report = pending_reports.pop_front();
				if (pair_low !== head_report.pair_low) begin
					$error("pair_low: expected %0d, got %0d", head_report.pair_low, pair_low);
					err_count++;
				end
				if (pair_high !== head_report.pair_high) begin
					$error("pair_high: expected %0d, got %0d", head_report.pair_high, pair_high);
					err_count++;
				end
				if (frame_done !== head_report.frame_done) begin
					$error("frame_done: expected %0d, got %0d", head_report.frame_done, frame_done);
					err_count++;
				end
				if (pair_count !== head_report.pair_count) begin
					$error("pair_count: expected %0d, got %0d", head_report.pair_count, pair_count);
					err_count++;
				end
			end
		end
	end

	// A size of zero acts as one, and sizes beyond the store act as the store size.
	function automatic int unsigned usable_size(input logic [CFG_W-1:0] v, input int unsigned cap);
		if (v == '0) return 1;
		if (int'(v) > cap) return cap;
		return int'(v);
	endfunction

	// Record an unordered pair; only the first sighting in a frame is reported.
	task automatic note_pair(input logic [LBL_W-1:0] a, input logic [LBL_W-1:0] b);
		logic [LBL_W-1:0] lo;
		logic [LBL_W-1:0] hi;
		int idx;
		result_t rep;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		idx = int'(lo) * DEF_LABEL_COUNT + int'(hi);
		if (pair_seen[idx]) return;
		pair_seen[idx] = 1'b1;
		seen_list.insert(seen_list.size(), idx);
		if (pairs_found != CNT_MAX) pairs_found++;
		rep.pair_low = lo;
		rep.pair_high = hi;
		rep.frame_done = 1'b0;
		rep.pair_count = '0;
		pending_reports.insert(pending_reports.size(), rep);
	endtask

	// Advance the scan by one pixel and queue the results it causes.
	task automatic scan_pixel(input logic [LBL_W-1:0] lbl);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		bit last_c;
		bit last_r;
		logic [LBL_W-1:0] up;
		result_t rep;
		w = usable_size(size_w, MAXW);
		h = usable_size(size_h, MAXH);
		c = (scan_col >= w) ? w - 1 : scan_col;
		r = (scan_row >= h) ? h - 1 : scan_row;
		last_c = (c + 1 >= w);
		last_r = (r + 1 >= h);
		if (c == 0) row_head = lbl;
		if (c >= 1 && left_lbl != lbl) note_pair(left_lbl, lbl);
		if (r >= 1) begin
			up = line_above[c];
			if (c >= 1 && diag_lbl != lbl) note_pair(diag_lbl, lbl);
			if (up != lbl) note_pair(up, lbl);
			if (c + 2 < w && line_above[c+1] != lbl) note_pair(line_above[c+1], lbl);
			diag_lbl = up;
		end else begin
			top_line[c] = lbl;
		end
		line_above[c] = lbl;
		// Wrap links pair even equal labels.
		if (last_r) note_pair(top_line[c], lbl);
		if (last_c) note_pair(row_head, lbl);
		left_lbl = lbl;
		if (last_c) begin
			scan_col = 0;
			if (last_r) begin
				rep.pair_low = '0;
				rep.pair_high = '0;
				rep.frame_done = 1'b1;
				rep.pair_count = pairs_found;
				pending_reports.insert(pending_reports.size(), rep);
				foreach (seen_list[i]) pair_seen[seen_list[i]] = 1'b0;
				seen_list.delete();
				pairs_found = '0;
				scan_row = 0;
			end else begin
				scan_row = r + 1;
			end
		end else begin
			scan_col = c + 1;
			scan_row = r;
		end
	endtask

	// Offer one pixel request, with random gaps ahead of it, and predict on acceptance.
	task automatic send_pixel(input logic [LBL_W-1:0] lbl);
		if ($urandom_range(99) < src_idle_pct) begin
			pixel_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		pixel_valid <= 1'b1;
		pixel_label <= lbl;
		do @(posedge clk); while (!pixel_ready);
		scan_pixel(lbl);
	endtask

	// Hold the sender off until every predicted result has been seen.
	task automatic wait_for_reports();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	// Write both size registers while the block is quiet.
	task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		wait_for_reports();
		repeat (QUIET_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
		size_w = w;
		size_h = h;
	endtask

	// Zero sizes, a single column and a single row: every pixel meets a wrap link.
	task automatic test_size_one();
		set_frame_size(10'd0, 10'd0);
		send_pixel(8'd255);
		set_frame_size(10'd1, 10'd3);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		set_frame_size(10'd3, 10'd1);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd255);
	endtask

	// A 3x3 frame of distinct labels touches every neighbor direction.
	task automatic test_neighbours();
		logic [LBL_W-1:0] lbls [0:8];
		lbls = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd255};
		set_frame_size(10'd3, 10'd3);
		foreach (lbls[i]) send_pixel(lbls[i]);
	endtask

	// Shrink the frame part way through; the scan position is clamped to the new last pixel.
	task automatic test_midframe_resize();
		set_frame_size(10'd4, 10'd4);
		for (int i = 0; i < 6; i++) send_pixel(8'(i * 37 + 5));
		set_frame_size(10'd2, 10'd2);
		send_pixel(8'd200);
	endtask

	// Oversize registers: a long row and a tall column, each cut short by shrinking mid-frame.
	task automatic test_oversize();
		set_frame_size(10'd1023, 10'd1);
		for (int i = 0; i < 10; i++) send_pixel(8'($urandom_range(15)));
		set_frame_size(10'd3, 10'd1);
		send_pixel(8'($urandom_range(15)));
		set_frame_size(10'd1, 10'd1023);
		for (int i = 0; i < 5; i++) send_pixel(8'($urandom_range(255)));
		set_frame_size(10'd1, 10'd2);
		send_pixel(8'($urandom_range(255)));
	endtask

	// Whole frames of random size and content, sizes changed between frames.
	task automatic test_random_frames(input int unsigned item_goal);
		int unsigned sent;
		int unsigned w;
		int unsigned h;
		int unsigned npix;
		int unsigned mode;
		int unsigned pause_at;
		logic [LBL_W-1:0] base;
		sent = 0;
		while (sent < item_goal) begin
			case ($urandom_range(9))
				0: w = $urandom_range(1);
				1: w = $urandom_range(16, 9);
				default: w = $urandom_range(6, 2);
			endcase
			case ($urandom_range(9))
				0: h = $urandom_range(1);
				1: h = $urandom_range(8, 6);
				default: h = $urandom_range(4, 2);
			endcase
			set_frame_size(CFG_W'(w), CFG_W'(h));
			npix = usable_size(CFG_W'(w), MAXW) * usable_size(CFG_W'(h), MAXH);
			mode = $urandom_range(3);
			base = LBL_W'($urandom_range(255));
			pause_at = ($urandom_range(3) == 0) ? npix / 2 : npix;
			for (int unsigned k = 0; k < npix; k++) begin
				if (k == pause_at && k != 0) wait_for_reports();
				// Narrow label sets give equal neighbors and repeated pairs.
				if (mode == 0) send_pixel(LBL_W'($urandom_range(255)));
				else send_pixel(base + LBL_W'($urandom_range(2)));
			end
			sent += npix;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 14;
		snk_idle_pct = 49;
		test_size_one();
		test_neighbours();
		test_midframe_resize();
		test_random_frames(30);

		src_idle_pct = 49;
		snk_idle_pct = 14;
		test_random_frames(30);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_frames(30);
		test_oversize();

		wait_for_reports();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("superpixel_adjacency_builder_tb: done, clean");
		end else begin
			$display("superpixel_adjacency_builder_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sab_pkg.sv
rtl/sab_scan.sv
rtl/sab_pair_table.sv
rtl/sab_out_fifo.sv
rtl/superpixel_adjacency_builder.sv
test/superpixel_adjacency_builder_tb.sv
